// ===== design/multi_servo_linear_ramp_unit_macros.svh =====
// Assertion macros for the multi-servo linear ramp unit.
`ifndef MULTI_SERVO_LINEAR_RAMP_UNIT_MACROS_SVH
`define MULTI_SERVO_LINEAR_RAMP_UNIT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define MSLR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MSLR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mslr_pkg.sv =====
// Types and constants of the multi-servo linear ramp unit.
package mslr_pkg;

  localparam int DEF_NUM_SERVOS = 16;

  // Field widths.
  localparam int ID_W   = 4;
  localparam int ANG_W  = 13;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;

  // Input beat layout, lowest bits first.
  localparam int ID_LSB   = 0;
  localparam int ANG_LSB  = ID_LSB + ID_W;
  localparam int DUR_LSB  = ANG_LSB + ANG_W;
  localparam int TIME_LSB = DUR_LSB + DUR_W;
  localparam int S_FIELDS_W = TIME_LSB + TIME_W;
  localparam int S_DATA_W = ((S_FIELDS_W + 7) / 8) * 8;

  // Output beat layout.
  localparam int M_FIELDS_W = ID_W + ANG_W;
  localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W  = M_DATA_W - M_FIELDS_W;

  // The interpolation step magnitude is below 2^ANG_W, so the divider
  // needs one step per angle bit.
  localparam int PROD_W     = ANG_W + DUR_W;
  localparam int DIV_STEPS  = ANG_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic OP_SET    = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic signed [ANG_W-1:0] start;
    logic signed [ANG_W-1:0] goal;
    logic [DUR_W-1:0]        len;
    logic [TIME_W-1:0]       t0;
  } ramp_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SET  = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_READ = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_SUM  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

endpackage

// ===== design/multi_servo_linear_ramp_unit.sv =====
// Multi-channel timed linear ramp engine for servo drive angles.
// A set beat with zero duration jumps its channel and presents one result beat
// through the emit state, once the output is free; a set beat with a duration
// starts a ramp through the set state and returns nothing. A set beat for a
// servo id that does not exist is taken and dropped. An update beat, if any
// channel is moving, walks the channels in index order up to the last moving
// one: it skips a channel that is not moving, reads and emits a moving channel
// that reaches its goal, and for one that is still ramping reads, multiplies,
// runs the bit-serial divider that scales the angle step, sums and emits.
// Output stalls hold the walk in its emit state. Per-channel state lives in two
// single-port memories with registered reads: the present angle and the ramp
// description.
// Result beats carry tlast on the final result of each input beat.
`include "multi_servo_linear_ramp_unit_macros.svh"

module multi_servo_linear_ramp_unit
  import mslr_pkg::*;
#(
  parameter int NUM_SERVOS = DEF_NUM_SERVOS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // servo_id[3:0], target[16:4], duration_ms[32:17], now_ms[64:33], zero pad
  input  logic [S_DATA_W-1:0] s_tdata,
  // op
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // servo_id_res[3:0], angle[16:4], zero pad
  output logic [M_DATA_W-1:0] m_tdata,
  // motion_done
  output logic                m_tuser,
  output logic                m_tlast
);

  localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  state_t state, state_next;

  logic signed [ANG_W-1:0] mem_cur  [NUM_SERVOS];
  ramp_t                   mem_ramp [NUM_SERVOS];
  logic signed [ANG_W-1:0] rd_cur;
  ramp_t                   rd_ramp;

  logic [NUM_SERVOS-1:0] moving;
  logic [NUM_SERVOS-1:0] written;

  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        id_q;
  logic signed [ANG_W-1:0] tgt_q;
  logic [DUR_W-1:0]        dur_q;
  logic [TIME_W-1:0]       now_q;

  logic                    neg_q;
  logic [ANG_W-1:0]        mag_q;
  logic [DUR_W-1:0]        elp_q;
  logic [DUR_W-1:0]        len_q;
  logic signed [ANG_W-1:0] start_q;
  logic [DUR_W-1:0]        rem;
  logic [ANG_W-1:0]        quo;
  logic [DIV_CNT_W-1:0]    div_cnt;

  logic [IDX_W-1:0]        res_idx;
  logic signed [ANG_W-1:0] res_angle;
  logic                    res_done;
  logic                    res_last;

  logic [ID_W-1:0]         in_id;
  logic signed [ANG_W-1:0] in_tgt;
  logic [DUR_W-1:0]        in_dur;
  logic [TIME_W-1:0]       in_now;
  logic                    in_op;
  logic                    s_accept;
  logic                    id_ok;
  logic                    out_free;
  logic                    emit_fire;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [TIME_W-1:0]       elapsed;
  logic                    reach_goal;
  logic signed [ANG_W:0]   diff;
  logic [NUM_SERVOS-1:0]   moving_above;
  logic [PROD_W-1:0]       product;
  logic [DUR_W:0]          partial;
  logic                    sub_ok;
  logic signed [ANG_W:0]   step;
  logic signed [ANG_W:0]   sum;

  assign in_id  = s_tdata[ID_LSB +: ID_W];
  assign in_tgt = s_tdata[ANG_LSB +: ANG_W];
  assign in_dur = s_tdata[DUR_LSB +: DUR_W];
  assign in_now = s_tdata[TIME_LSB +: TIME_W];
  assign in_op  = s_tuser;

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign id_ok     = (32'(in_id) < NUM_SERVOS);
  assign out_free  = !m_tvalid || m_tready;
  assign emit_fire = (state == S_EMIT) && out_free;

  // Only a ramping set and a walk step that lands on a moving channel read.
  assign rd_en = (s_accept && in_op == OP_SET && id_ok && in_dur != '0) ||
                 (state == S_SCAN && moving[idx]);
  assign rd_addr = (state == S_IDLE) ? IDX_W'(in_id) : idx;

  assign elapsed      = now_q - rd_ramp.t0;
  assign reach_goal   = (elapsed >= TIME_W'(rd_ramp.len));
  assign diff         = {rd_ramp.goal[ANG_W-1], rd_ramp.goal} -
                        {rd_ramp.start[ANG_W-1], rd_ramp.start};
  assign moving_above = (moving >> idx) >> 1;

  assign product = PROD_W'(mag_q) * PROD_W'(elp_q);
  assign partial = {rem, quo[ANG_W-1]};
  assign sub_ok  = (partial >= {1'b0, len_q});
  assign step    = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum     = {start_q[ANG_W-1], start_q} + step;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          if (in_op == OP_SET) begin
            if (id_ok) begin
              state_next = (in_dur == '0) ? S_EMIT : S_SET;
            end
          end else if (moving != '0) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SET:  state_next = S_IDLE;
      S_SCAN: begin
        if (moving[idx]) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = reach_goal ? S_EMIT : S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == '0) begin
          state_next = S_SUM;
        end
      end
      S_SUM:  state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = res_last ? S_IDLE : S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      moving   <= '0;
      written  <= '0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_SET) begin
        moving[id_q] <= 1'b1;
      end
      if (emit_fire) begin
        written[res_idx] <= 1'b1;
        if (res_done) begin
          moving[res_idx] <= 1'b0;
        end
      end
    end
  end

  // Channel memories: registered reads, writes from the set and emit steps.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cur  <= mem_cur[rd_addr];
      rd_ramp <= mem_ramp[rd_addr];
    end
    if (emit_fire) begin
      mem_cur[res_idx] <= res_angle;
    end
    if (state == S_SET) begin
      mem_ramp[id_q] <= '{start: written[id_q] ? rd_cur : '0,
                          goal:  tgt_q,
                          len:   dur_q,
                          t0:    now_q};
    end
  end

  // Datapath and output register.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          id_q      <= IDX_W'(in_id);
          tgt_q     <= in_tgt;
          dur_q     <= in_dur;
          now_q     <= in_now;
          idx       <= '0;
          res_idx   <= IDX_W'(in_id);
          res_angle <= in_tgt;
          res_done  <= 1'b1;
          res_last  <= 1'b1;
        end
      end
      S_SCAN: begin
        if (!moving[idx]) begin
          idx <= idx + 1'b1;
        end
      end
      S_READ: begin
        res_idx   <= idx;
        res_last  <= (moving_above == '0);
        res_done  <= reach_goal;
        res_angle <= rd_ramp.goal;
        neg_q     <= diff[ANG_W];
        mag_q     <= diff[ANG_W] ? ANG_W'(-diff) : ANG_W'(diff);
        elp_q     <= elapsed[DUR_W-1:0];
        len_q     <= rd_ramp.len;
        start_q   <= rd_ramp.start;
      end
      S_MUL: begin
        // The product is below len * 2^ANG_W, so its upper part already
        // stands below the divisor as the first partial remainder.
        rem     <= product[PROD_W-1 -: DUR_W];
        quo     <= product[ANG_W-1:0];
        div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
      end
      S_DIV: begin
        if (sub_ok) begin
          rem <= DUR_W'(partial - {1'b0, len_q});
        end else begin
          rem <= partial[DUR_W-1:0];
        end
        quo     <= {quo[ANG_W-2:0], sub_ok};
        div_cnt <= div_cnt - 1'b1;
      end
      S_SUM: begin
        res_angle <= sum[ANG_W-1:0];
      end
      S_EMIT: begin
        if (out_free && !res_last) begin
          idx <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (emit_fire) begin
      m_tdata <= {{M_PAD_W{1'b0}}, res_angle, ID_W'(res_idx)};
      m_tuser <= res_done;
      m_tlast <= res_last;
    end
  end

  `MSLR_ASSERT(a_div_rem_below_len, state == S_DIV |-> rem < len_q, "divider remainder not below ramp length")
  `MSLR_ASSERT(a_scan_finds_channel, state == S_SCAN |-> (moving >> idx) != '0, "walk running with no moving channel ahead")
  `MSLR_ASSERT(a_more_after_nonlast, m_tvalid && m_tready && !m_tlast |-> state != S_IDLE, "non-final result taken with the walk already over")
  `MSLR_ASSERT_ALWAYS(a_reset_idle, rst |=> state == S_IDLE && !m_tvalid && moving == '0, "reset did not return the block to idle")

endmodule
